FILE: rtl/core/harmonic_additive_oscillator_top_assert.svh
// Assertion macros used by the oscillator RTL.
// Depends on nothing; include by bare file name.
`ifndef HARMONIC_ADDITIVE_OSCILLATOR_TOP_ASSERT_SVH
`define HARMONIC_ADDITIVE_OSCILLATOR_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define HAO_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define HAO_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/hao_pkg.sv
// Package for the additive harmonic oscillator: field widths, queue item,
// sequencer states and the quarter-wave sine generator. Depends on nothing.
`timescale 1ns / 1ps

package hao_pkg;

   localparam int FUND_W     = 24;
   localparam int AMP_W      = 16;
   localparam int SAMPLE_W   = 24;
   localparam int PHASE_W    = 32;
   localparam int ACC_W      = 40;
   localparam int COUNT_W    = 8;
   localparam int SINE_W     = 16;
   localparam int INC_PROD_W = FUND_W + PHASE_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Register indexes, taken from paddr bit 2.
   localparam logic REG_NUM_HARMONICS = 1'b0;
   localparam logic REG_PHASE_STEP    = 1'b1;

   localparam logic [COUNT_W-1:0] NUM_HARMONICS_RESET = 8'd1;
   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET    = 32'd22906492;

   // pi in Q2.30 and the Taylor denominators (2n)(2n+1).
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156};

   typedef struct packed {
      logic [FUND_W-1:0]        fundamental;
      logic signed [AMP_W-1:0]  amplitude;
      logic                     first;
      logic                     last;
   } hao_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INC_MUL,
      ST_BASE_ADD,
      ST_LOOKUP,
      ST_MAC_MUL,
      ST_MAC_ACC,
      ST_EMIT
   } hao_state_type;

   // Quarter-wave magnitude, round(32767 * sin), evaluated at elaboration.
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned q,
                                                      input int unsigned abits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned v;
      x    = (longint'(q) * 64'd2 * PI_Q30) >> abits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return SINE_W'(v);
   endfunction

endpackage

FILE: rtl/core/hao_front.sv
// Front end: accepts requests and tags each as first and/or last of a run.
// Depends on hao_pkg.
`timescale 1ns / 1ps

module hao_front #(
   parameter int MAX_HARMONICS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hao_pkg::FUND_W-1:0]    req_fundamental,
   input  logic signed [hao_pkg::AMP_W-1:0] req_amplitude,
   input  logic [hao_pkg::COUNT_W-1:0]   num_harmonics,
   input  logic                          q_full,
   output logic                          q_push,
   output hao_pkg::hao_item_type         q_item
);
   import hao_pkg::*;

   localparam logic [COUNT_W:0] MAX_LIMIT = (COUNT_W+1)'(MAX_HARMONICS);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W:0]   limit;
   logic [COUNT_W:0]   count_next;
   logic               last;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      if (num_harmonics == '0) begin
         limit = (COUNT_W+1)'(1);
      end else if ({1'b0, num_harmonics} > MAX_LIMIT) begin
         limit = MAX_LIMIT;
      end else begin
         limit = {1'b0, num_harmonics};
      end
      count_next = {1'b0, count_ff} + (COUNT_W+1)'(1);
      last       = (count_next >= limit);

      q_item.fundamental = req_fundamental;
      q_item.amplitude   = req_amplitude;
      q_item.first       = (count_ff == '0);
      q_item.last        = last;

      count_in = count_ff;
      if (q_push) begin
         count_in = last ? '0 : count_next[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/hao_queue.sv
// Short request queue between the front end and the sequencer.
// Depends on hao_pkg.
`timescale 1ns / 1ps

module hao_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hao_pkg::hao_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output hao_pkg::hao_item_type head
);
   import hao_pkg::*;

   hao_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff;
   logic [QCNT_W-1:0]  cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/hao_back.sv
// Back end: sequencer for phase advance, sine lookup, multiply-accumulate
// and the saturated output register. Depends on hao_pkg and the assert header.
`timescale 1ns / 1ps
`include "harmonic_additive_oscillator_top_assert.svh"

module hao_back #(
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  hao_pkg::hao_item_type            q_item,
   output logic                             q_pop,
   input  logic [hao_pkg::PHASE_W-1:0]      phase_step,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [hao_pkg::SAMPLE_W-1:0] rsp_sample_out
);
   import hao_pkg::*;

   localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
   localparam int QA_W    = SINE_ADDR_BITS - 1;
   localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'(8388607);
   localparam logic signed [ACC_W:0] SAT_MIN = -(ACC_W+1)'(8388608);

   // Quarter-wave ROM, entries 0 to QUARTER inclusive.
   logic [SINE_W-1:0] qtab [QUARTER+1];
   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      localparam logic [SINE_W-1:0] ENTRY = quarter_sine(g, SINE_ADDR_BITS);
      assign qtab[g] = ENTRY;
   end

   hao_state_type             state_ff;
   hao_state_type             state_in;
   hao_item_type              item_ff;
   hao_item_type              item_in;
   logic [INC_PROD_W-1:0]     inc_prod_ff;
   logic [INC_PROD_W-1:0]     inc_prod_in;
   logic [PHASE_W-1:0]        base_ff;
   logic [PHASE_W-1:0]        base_in;
   logic [PHASE_W-1:0]        hphase_ff;
   logic [PHASE_W-1:0]        hphase_in;
   logic [SINE_W-1:0]         mag_ff;
   logic [SINE_W-1:0]         mag_in;
   logic                      neg_ff;
   logic                      neg_in;
   logic signed [31:0]        prod_ff;
   logic signed [31:0]        prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_in;

   logic [SINE_ADDR_BITS-1:0] sine_idx;
   logic [SINE_ADDR_BITS-3:0] sine_q;
   logic [QA_W-1:0]           qaddr;
   logic signed [SINE_W-1:0]  sine_s;
   logic signed [ACC_W:0]     rounded;
   logic signed [ACC_W:0]     shifted;
   logic signed [SAMPLE_W-1:0] sat;
   logic                      slot_free;
   logic                      load_out;

   assign slot_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = q_item.first ? ST_INC_MUL : ST_LOOKUP;
            end
         end
         ST_INC_MUL:  state_in = ST_BASE_ADD;
         ST_BASE_ADD: state_in = ST_LOOKUP;
         ST_LOOKUP:   state_in = ST_MAC_MUL;
         ST_MAC_MUL:  state_in = ST_MAC_ACC;
         ST_MAC_ACC:  state_in = item_ff.last ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && q_valid;
      load_out = (state_ff == ST_EMIT) && slot_free;
   end

   // Datapath.
   always_comb begin
      sine_idx = hphase_ff[PHASE_W-1 -: SINE_ADDR_BITS];
      sine_q   = sine_idx[SINE_ADDR_BITS-3:0];
      if (sine_idx[SINE_ADDR_BITS-2]) begin
         qaddr = QA_W'(QUARTER) - {1'b0, sine_q};
      end else begin
         qaddr = {1'b0, sine_q};
      end
      sine_s = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

      rounded = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(64);
      shifted = rounded >>> 7;
      if (shifted > SAT_MAX) begin
         sat = SAMPLE_W'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         sat = SAMPLE_W'(SAT_MIN);
      end else begin
         sat = shifted[SAMPLE_W-1:0];
      end

      item_in     = q_pop ? q_item : item_ff;
      inc_prod_in = inc_prod_ff;
      base_in     = base_ff;
      hphase_in   = hphase_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;

      case (state_ff)
         ST_INC_MUL: begin
            inc_prod_in = INC_PROD_W'(item_ff.fundamental) * INC_PROD_W'(phase_step);
         end
         ST_BASE_ADD: begin
            base_in   = base_ff + inc_prod_ff[PHASE_W+15:16];
            hphase_in = base_in;
            acc_in    = '0;
         end
         ST_LOOKUP: begin
            mag_in = qtab[qaddr];
            neg_in = sine_idx[SINE_ADDR_BITS-1];
         end
         ST_MAC_MUL: begin
            prod_in   = 32'(item_ff.amplitude) * 32'(sine_s);
            hphase_in = hphase_ff + base_ff;
         end
         ST_MAC_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         default: begin
         end
      endcase

      rsp_sample_in = load_out ? sat : rsp_sample_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      inc_prod_ff   <= inc_prod_in;
      hphase_ff     <= hphase_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   `HAO_ASSERT_NEXT(a_emit_loads_output, clock, reset, (state_ff == ST_EMIT) && slot_free, rsp_valid_ff, "emit did not raise rsp_valid")
   `HAO_ASSERT_NEXT(a_first_runs_increment, clock, reset, q_pop && q_item.first, state_ff == ST_INC_MUL, "first harmonic skipped phase advance")
   `HAO_ASSERT_NEXT(a_later_skips_increment, clock, reset, q_pop && !q_item.first, state_ff == ST_LOOKUP, "later harmonic advanced phase")
   `HAO_ASSERT_SAME(a_emit_only_on_last, clock, reset, state_ff == ST_EMIT, item_ff.last, "sample emitted before the last harmonic")

endmodule

FILE: rtl/core/harmonic_additive_oscillator_top.sv
// Top level of the additive harmonic oscillator: CSR block and wiring of
// front end, request queue and sequencer. Depends on hao_pkg and the hao_* modules.
`timescale 1ns / 1ps

// Usage
//   Send one request per harmonic on req_*: harmonic 1 first, each with its
//   Q1.15 amplitude; req_fundamental is used only on the first request of a
//   run. After num_harmonics requests one Q1.23 sample appears on rsp_*.
//   Both channels use valid/stall; a transfer happens when valid is high and
//   stall is low. The CSR port is APB style: num_harmonics at 0x0,
//   phase_step_per_hz at 0x4, pready always high. Write CSRs only while idle.
// Sequencing
//   Each harmonic passes through pop, table read, multiply and accumulate.
//   The first harmonic of a run adds the fundamental-times-step multiply and
//   phase add between pop and table read, and the last adds a step to load
//   the output register. A harmonic is popped only once the one before it is
//   done; a 4-entry queue lets requests arrive while the sequencer works.
// Reset and stall
//   Reset (synchronous) clears the phase, the run counter, the queue and the
//   output valid, and loads the CSR defaults. A stalled response holds in the
//   output register; the sequencer waits in its emit step while the queue
//   keeps taking requests until it fills, then req_stall rises.

module harmonic_additive_oscillator_top #(
   parameter int MAX_HARMONICS  = 128,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hao_pkg::FUND_W-1:0]          req_fundamental,
   input  logic signed [hao_pkg::AMP_W-1:0]    req_amplitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [hao_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hao_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hao_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hao_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import hao_pkg::*;

   logic [COUNT_W-1:0] num_harmonics_ff;
   logic [COUNT_W-1:0] num_harmonics_in;
   logic [PHASE_W-1:0] phase_step_ff;
   logic [PHASE_W-1:0] phase_step_in;
   logic               csr_write;
   logic               csr_index;

   hao_item_type       front_item;
   hao_item_type       head_item;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;

   // CSR access: write on the access phase, read mux on the index bit.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      num_harmonics_in = num_harmonics_ff;
      phase_step_in    = phase_step_ff;
      if (csr_write) begin
         case (csr_index)
            REG_NUM_HARMONICS: num_harmonics_in = csr_pwdata[COUNT_W-1:0];
            REG_PHASE_STEP:    phase_step_in    = csr_pwdata[PHASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NUM_HARMONICS: csr_prdata = CSR_DATA_W'(num_harmonics_ff);
         REG_PHASE_STEP:    csr_prdata = CSR_DATA_W'(phase_step_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_harmonics_ff <= NUM_HARMONICS_RESET;
         phase_step_ff    <= PHASE_STEP_RESET;
      end else begin
         num_harmonics_ff <= num_harmonics_in;
         phase_step_ff    <= phase_step_in;
      end
   end

   // Front end: take requests, tag first and last of each run.
   hao_front #(
      .MAX_HARMONICS (MAX_HARMONICS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_fundamental (req_fundamental),
      .req_amplitude   (req_amplitude),
      .num_harmonics   (num_harmonics_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (front_item)
   );

   // Decouple the front end from the sequencer.
   hao_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (head_item)
   );

   // Sequencer: phase advance, sine lookup, multiply-accumulate, output.
   hao_back #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .phase_step     (phase_step_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
